// ===== src/rbm_gs_pkg.sv =====
// ----------------------------------------------------------------------------
// RBM Gibbs unit sampler package
// Shared constants, codes and the sigmoid probability table.
// ----------------------------------------------------------------------------
package rbm_gs_pkg;

  localparam int NumVisibleDef = 64;
  localparam int NumHiddenDef  = 64;
  localparam int NumLabelDef   = 32;

  localparam int AccW     = 24;
  localparam int WeightW  = 16;
  localparam int ProbW    = 16;
  localparam int RomDepth = 1024;
  localparam int RomAw    = 10;

  typedef enum logic [3:0] {
    ACT_WR_VIS_WEIGHT = 4'd0,
    ACT_WR_LAB_WEIGHT = 4'd1,
    ACT_WR_VIS_BIAS   = 4'd2,
    ACT_WR_HID_BIAS   = 4'd3,
    ACT_WR_LAB_BIAS   = 4'd4,
    ACT_SET_VIS_BIT   = 4'd5,
    ACT_SET_LAB_BIT   = 4'd6,
    ACT_SAMPLE_HID    = 4'd7,
    ACT_SAMPLE_VIS    = 4'd8,
    ACT_SAMPLE_LAB    = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_WALK,
    ST_DRAIN,
    ST_ROM,
    ST_FIN
  } state_e;

  typedef logic [ProbW-1:0] prob_rom_t [RomDepth];

  // Unsigned long division, one quotient bit per step; used only while the
  // table below is built.
  function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Probability for every 1/64 step of the pre-activation over [-8, 8).
  function automatic prob_rom_t build_prob_rom();
    prob_rom_t   rom;
    logic [63:0] one_q60;
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] e [513];
    logic [127:0] prod;
    logic [63:0] e40;
    logic [63:0] d;
    logic [63:0] num;
    int          m;
    int          t;
    one_q60 = 64'd1 << 60;
    step    = one_q60;
    term    = one_q60;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term >> 6, 64'(n));
      if (n[0]) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    e[0] = one_q60;
    for (int n = 1; n <= 512; n++) begin
      prod = 128'(e[n-1]) * 128'(step);
      e[n] = prod[123:60];
    end
    for (int idx = 0; idx < RomDepth; idx++) begin
      m   = idx - 512;
      t   = (m < 0) ? -m : m;
      e40 = e[t] >> 20;
      d   = (64'd1 << 40) + e40;
      num = (m >= 0) ? (64'd65535 << 40) : (64'd65535 * e40);
      rom[idx] = ProbW'(udiv64((num << 1) + d, d << 1));
    end
    return rom;
  endfunction

  localparam prob_rom_t ProbRom = build_prob_rom();

endpackage

// ===== src/rbm_gibbs_unit_sampler_top.sv =====
// ----------------------------------------------------------------------------
// RBM Gibbs unit sampler
// Loads weights, biases and state bits of a conditional RBM and samples
// one hidden, visible or label unit per request.
// ----------------------------------------------------------------------------
// Each request is handled on its own. A load request (weight and bias writes,
// visible and label bit sets) goes straight to the finish state and reaches
// the output register from there. A sample request reads the unit's bias,
// then walks the weight memory one word per cycle: a hidden unit walks
// NUM_VISIBLE + NUM_LABEL weights, a visible or label unit walks NUM_HIDDEN
// weights. It then passes through the drain and table lookup states to the
// finish state, from which its result reaches the output register. The
// single read port of the weight memory sets the pace of the walk, and a
// stalled output register holds the request in the finish state. Weights
// whose partner bit is clear are read but not added. The 24-bit sum
// saturates, is clamped to [-8, 8) and indexes a 1024-entry sigmoid table;
// the sampled bit is stored back into the unit's state. The result waits in
// an output register, and the next request is taken once the current one
// has been handed to that register. Weight and bias memories have no reset;
// bit vectors reset to zero.
module rbm_gibbs_unit_sampler_top
  import rbm_gs_pkg::*;
#(
  parameter int NUM_VISIBLE = NumVisibleDef,
  parameter int NUM_HIDDEN  = NumHiddenDef,
  parameter int NUM_LABEL   = NumLabelDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                action_i,
  input  logic [5:0]                hidden_index_i,
  input  logic [5:0]                unit_index_i,
  input  logic signed [WeightW-1:0] weight_value_i,
  input  logic                      bit_value_i,
  input  logic [15:0]               random_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      sample_bit_o,
  output logic [ProbW-1:0]          probability_o
);

  // Weight memory: visible weights first, then label weights.
  localparam int VwDepth = NUM_HIDDEN * NUM_VISIBLE;
  localparam int WtDepth = VwDepth + NUM_HIDDEN * NUM_LABEL;
  localparam int WaW     = $clog2(WtDepth);
  // Bias memory: visible, hidden, then label biases.
  localparam int BiDepth = NUM_VISIBLE + NUM_HIDDEN + NUM_LABEL;
  localparam int BaW     = $clog2(BiDepth);
  localparam int SelW    = (NUM_VISIBLE + NUM_LABEL > NUM_HIDDEN) ?
                           (NUM_VISIBLE + NUM_LABEL) : NUM_HIDDEN;
  localparam int CntW    = $clog2(SelW + 1);

  logic [WeightW-1:0] wt_mem [WtDepth];
  logic [WeightW-1:0] bias_mem [BiDepth];

  state_e state_q, state_d;

  logic [NUM_VISIBLE-1:0] vis_bits_q;
  logic [NUM_HIDDEN-1:0]  hid_bits_q;
  logic [NUM_LABEL-1:0]   lab_bits_q;

  logic [3:0]          action_q;
  logic [5:0]          hid_idx_q;
  logic [5:0]          unit_idx_q;
  logic [15:0]         rnd_q;
  logic                is_sample_q;

  logic [WaW-1:0]      waddr_q;
  logic [WaW-1:0]      step_q;
  logic [WaW-1:0]      lab_start_q;
  logic [BaW-1:0]      baddr_q;
  logic [SelW-1:0]     sel_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     total_q;
  logic                pend_q;
  logic                flag_q;

  logic [WeightW-1:0]  wt_rdata_q;
  logic [WeightW-1:0]  bias_rdata_q;
  logic signed [AccW-1:0] acc_q;
  logic [ProbW-1:0]    rom_q;

  logic                out_valid_q;
  logic                sample_bit_q;
  logic [ProbW-1:0]    probability_q;

  logic                accept;
  logic                hid_ok;
  logic                vis_ok;
  logic                lab_ok;
  logic                sample_ok;
  logic                out_load;
  logic                res_bit;
  logic signed [AccW:0] sum;
  logic signed [AccW-1:0] sat_sum;
  logic signed [15:0]  clamped;
  logic [RomAw-1:0]    rom_idx;
  logic [WaW-1:0]      h_vis_base;
  logic [WaW-1:0]      h_lab_base;

  assign accept = in_valid_i && in_ready_o;
  assign hid_ok = 32'(hidden_index_i) < NUM_HIDDEN;
  assign vis_ok = 32'(unit_index_i) < NUM_VISIBLE;
  assign lab_ok = 32'(unit_index_i) < NUM_LABEL;

  assign h_vis_base = WaW'(hidden_index_i) * WaW'(NUM_VISIBLE);
  assign h_lab_base = WaW'(VwDepth) + WaW'(hidden_index_i) * WaW'(NUM_LABEL);

  always_comb begin
    case (action_e'(action_i))
      ACT_SAMPLE_HID: sample_ok = hid_ok;
      ACT_SAMPLE_VIS: sample_ok = vis_ok;
      ACT_SAMPLE_LAB: sample_ok = lab_ok;
      default:        sample_ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = sample_ok ? ST_BIAS : ST_FIN;
        end
      end
      ST_BIAS: state_d = ST_WALK;
      ST_WALK: begin
        if (cnt_q == total_q - CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_ROM;
      ST_ROM:   state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_FIN:  out_load   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Memories: one write port (load requests), one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && hid_ok && vis_ok && action_e'(action_i) == ACT_WR_VIS_WEIGHT) begin
      wt_mem[h_vis_base + WaW'(unit_index_i)] <= weight_value_i;
    end
    if (accept && hid_ok && lab_ok && action_e'(action_i) == ACT_WR_LAB_WEIGHT) begin
      wt_mem[h_lab_base + WaW'(unit_index_i)] <= weight_value_i;
    end
    wt_rdata_q <= wt_mem[waddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && vis_ok && action_e'(action_i) == ACT_WR_VIS_BIAS) begin
      bias_mem[BaW'(unit_index_i)] <= weight_value_i;
    end
    if (accept && hid_ok && action_e'(action_i) == ACT_WR_HID_BIAS) begin
      bias_mem[BaW'(NUM_VISIBLE) + BaW'(hidden_index_i)] <= weight_value_i;
    end
    if (accept && lab_ok && action_e'(action_i) == ACT_WR_LAB_BIAS) begin
      bias_mem[BaW'(NUM_VISIBLE + NUM_HIDDEN) + BaW'(unit_index_i)] <= weight_value_i;
    end
    bias_rdata_q <= bias_mem[baddr_q];
  end

  // Request capture and walk setup.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q    <= action_i;
      hid_idx_q   <= hidden_index_i;
      unit_idx_q  <= unit_index_i;
      rnd_q       <= random_value_i;
      is_sample_q <= sample_ok;
      lab_start_q <= h_lab_base;
      case (action_e'(action_i))
        ACT_SAMPLE_HID: begin
          baddr_q <= BaW'(NUM_VISIBLE) + BaW'(hidden_index_i);
          waddr_q <= h_vis_base;
          step_q  <= WaW'(1);
          sel_q   <= SelW'({lab_bits_q, vis_bits_q});
          total_q <= CntW'(NUM_VISIBLE + NUM_LABEL);
        end
        ACT_SAMPLE_VIS: begin
          baddr_q <= BaW'(unit_index_i);
          waddr_q <= WaW'(unit_index_i);
          step_q  <= WaW'(NUM_VISIBLE);
          sel_q   <= SelW'(hid_bits_q);
          total_q <= CntW'(NUM_HIDDEN);
        end
        default: begin
          baddr_q <= BaW'(NUM_VISIBLE + NUM_HIDDEN) + BaW'(unit_index_i);
          waddr_q <= WaW'(VwDepth) + WaW'(unit_index_i);
          step_q  <= WaW'(NUM_LABEL);
          sel_q   <= SelW'(hid_bits_q);
          total_q <= CntW'(NUM_HIDDEN);
        end
      endcase
    end else if (state_q == ST_WALK) begin
      sel_q <= sel_q >> 1;
      if (action_e'(action_q) == ACT_SAMPLE_HID &&
          cnt_q == CntW'(NUM_VISIBLE - 1)) begin
        waddr_q <= lab_start_q;
      end else begin
        waddr_q <= waddr_q + step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      pend_q <= (state_q == ST_WALK);
      flag_q <= sel_q[0];
      if (state_q == ST_WALK) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Saturating accumulate of the weight read in the previous cycle.
  assign sum = {acc_q[AccW-1], acc_q} + (AccW+1)'(signed'(wt_rdata_q));
  always_comb begin
    if (sum[AccW] != sum[AccW-1]) begin
      sat_sum = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat_sum = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WALK && cnt_q == '0) begin
      acc_q <= AccW'(signed'(bias_rdata_q));
    end else if (pend_q && flag_q) begin
      acc_q <= sat_sum;
    end
  end

  // Clamp to [-8, 8), drop the six low bits and look up the probability.
  always_comb begin
    if (acc_q > AccW'(32767)) begin
      clamped = 16'sh7fff;
    end else if (acc_q < -AccW'(32768)) begin
      clamped = 16'sh8000;
    end else begin
      clamped = acc_q[15:0];
    end
  end
  assign rom_idx = {~clamped[15], clamped[14:6]};

  always_ff @(posedge clk_i) begin
    rom_q <= ProbRom[rom_idx];
  end

  assign res_bit = rnd_q < rom_q;

  // State bits: set by load requests, written back by samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_bits_q <= '0;
      hid_bits_q <= '0;
      lab_bits_q <= '0;
    end else begin
      for (int j = 0; j < NUM_VISIBLE; j++) begin
        if (accept && action_e'(action_i) == ACT_SET_VIS_BIT &&
            32'(unit_index_i) == j) begin
          vis_bits_q[j] <= bit_value_i;
        end
        if (out_load && is_sample_q && action_e'(action_q) == ACT_SAMPLE_VIS &&
            32'(unit_idx_q) == j) begin
          vis_bits_q[j] <= res_bit;
        end
      end
      for (int j = 0; j < NUM_LABEL; j++) begin
        if (accept && action_e'(action_i) == ACT_SET_LAB_BIT &&
            32'(unit_index_i) == j) begin
          lab_bits_q[j] <= bit_value_i;
        end
        if (out_load && is_sample_q && action_e'(action_q) == ACT_SAMPLE_LAB &&
            32'(unit_idx_q) == j) begin
          lab_bits_q[j] <= res_bit;
        end
      end
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        if (out_load && is_sample_q && action_e'(action_q) == ACT_SAMPLE_HID &&
            32'(hid_idx_q) == j) begin
          hid_bits_q[j] <= res_bit;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_bit_q  <= is_sample_q ? res_bit : 1'b0;
      probability_q <= is_sample_q ? rom_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_bit_o  = sample_bit_q;
  assign probability_o = probability_q;

endmodule

// ===== sim/tb_rbm_gibbs_unit_sampler_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the RBM Gibbs unit sampler
// Fills every weight and bias entry the request streams can reach, then runs
// directed and random request streams under varying handshake idling and a
// long output stall, and checks each result against an in-bench model.
// ----------------------------------------------------------------------------
module tb_rbm_gibbs_unit_sampler_top;
  import rbm_gs_pkg::*;

  localparam int NumVis      = NumVisibleDef;
  localparam int NumHid      = NumHiddenDef;
  localparam int NumLab      = NumLabelDef;
  localparam int IdleLimit   = 5000;
  localparam int TailCycles  = 100;
  localparam int MaxReports  = 10;
  localparam int AccHi       = 8388607;
  localparam int AccLo       = -8388608;
  localparam int PickCount   = 8;

  // One request as it is offered to the sampler.
  typedef struct packed {
    logic [3:0]         action;
    logic [5:0]         hid;
    logic [5:0]         unit;
    logic signed [15:0] wval;
    logic               bval;
    logic [15:0]        rnd;
  } req_t;

  // One sampler answer.
  typedef struct packed {
    logic        sbit;
    logic [15:0] prob;
  } res_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [3:0]         action_i       = '0;
  logic [5:0]         hidden_index_i = '0;
  logic [5:0]         unit_index_i   = '0;
  logic signed [15:0] weight_value_i = '0;
  logic               bit_value_i    = 1'b0;
  logic [15:0]        random_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               sample_bit_o;
  logic [15:0]        probability_o;

  rbm_gibbs_unit_sampler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .hidden_index_i (hidden_index_i),
    .unit_index_i   (unit_index_i),
    .weight_value_i (weight_value_i),
    .bit_value_i    (bit_value_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_bit_o   (sample_bit_o),
    .probability_o  (probability_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the sampler's stores and unit states.
  logic signed [15:0] vis_w  [NumHid][NumVis];
  logic signed [15:0] lab_w  [NumHid][NumLab];
  logic signed [15:0] vis_b  [NumVis];
  logic signed [15:0] hid_b  [NumHid];
  logic signed [15:0] lab_b  [NumLab];
  logic               vis_st [NumVis];
  logic               hid_st [NumHid];
  logic               lab_st [NumLab];
  logic [15:0]        sigmoid_lut [1024];

  res_t expected_q [$];

  // Handshake idling controls, changed by the test tasks.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold     = 0;

  int mismatches  = 0;
  int checked     = 0;
  int n_sent      = 0;
  int n_samples   = 0;
  int n_noise     = 0;
  int n_mid_prob  = 0;
  int idle_cycles = 0;

  // The sigmoid steps are built from a fixed-point series for exp(-1/64),
  // raised to each power by repeated Q60 multiplication, then rounded.
  function automatic void build_sigmoid_lut();
    logic [63:0]  one;
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  pw [513];
    logic [127:0] prod;
    logic [63:0]  e40;
    logic [63:0]  den;
    logic [63:0]  num;
    int           m;
    int           t;
    one  = 64'd1 << 60;
    step = one;
    term = one;
    for (int n = 1; n <= 12; n++) begin
      term = (term >> 6) / 64'(n);
      if (n % 2 == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    pw[0] = one;
    for (int n = 1; n <= 512; n++) begin
      prod  = 128'(pw[n-1]) * 128'(step);
      pw[n] = prod[123:60];
    end
    for (int k = 0; k < 1024; k++) begin
      m   = k - 512;
      t   = (m < 0) ? -m : m;
      e40 = pw[t] >> 20;
      den = (64'd1 << 40) + e40;
      num = (m >= 0) ? (64'd65535 << 40) : (64'd65535 * e40);
      sigmoid_lut[k] = 16'((2 * num + den) / (2 * den));
    end
  endfunction

  function automatic int sat_accumulate(int acc, logic signed [15:0] w);
    int s;
    s = acc + int'(w);
    if (s > AccHi) s = AccHi;
    if (s < AccLo) s = AccLo;
    return s;
  endfunction

  function automatic logic [15:0] activation(int acc);
    int a;
    a = acc;
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    return sigmoid_lut[(a + 32768) >> 6];
  endfunction

  // Applies one request to the shadow state and returns the answer it gives.
  task automatic predict_sample(input req_t r, output res_t e);
    int          acc;
    logic [15:0] p;
    logic        s;
    logic        hit;
    e   = '0;
    hit = 1'b0;
    acc = 0;
    case (r.action)
      ACT_WR_VIS_WEIGHT: vis_w[r.hid][r.unit] = r.wval;
      ACT_WR_LAB_WEIGHT: if (r.unit < NumLab) lab_w[r.hid][r.unit] = r.wval;
      ACT_WR_VIS_BIAS:   vis_b[r.unit] = r.wval;
      ACT_WR_HID_BIAS:   hid_b[r.hid] = r.wval;
      ACT_WR_LAB_BIAS:   if (r.unit < NumLab) lab_b[r.unit] = r.wval;
      ACT_SET_VIS_BIT:   vis_st[r.unit] = r.bval;
      ACT_SET_LAB_BIT:   if (r.unit < NumLab) lab_st[r.unit] = r.bval;
      ACT_SAMPLE_HID: begin
        acc = hid_b[r.hid];
        for (int i = 0; i < NumVis; i++) begin
          if (vis_st[i]) acc = sat_accumulate(acc, vis_w[r.hid][i]);
        end
        for (int i = 0; i < NumLab; i++) begin
          if (lab_st[i]) acc = sat_accumulate(acc, lab_w[r.hid][i]);
        end
        hit = 1'b1;
      end
      ACT_SAMPLE_VIS: begin
        acc = vis_b[r.unit];
        for (int i = 0; i < NumHid; i++) begin
          if (hid_st[i]) acc = sat_accumulate(acc, vis_w[i][r.unit]);
        end
        hit = 1'b1;
      end
      ACT_SAMPLE_LAB: begin
        if (r.unit < NumLab) begin
          acc = lab_b[r.unit];
          for (int i = 0; i < NumHid; i++) begin
            if (hid_st[i]) acc = sat_accumulate(acc, lab_w[i][r.unit]);
          end
          hit = 1'b1;
        end
      end
      default: ;
    endcase
    if (hit) begin
      p = activation(acc);
      s = (r.rnd < p);
      case (r.action)
        ACT_SAMPLE_HID: hid_st[r.hid] = s;
        ACT_SAMPLE_VIS: vis_st[r.unit] = s;
        default:        lab_st[r.unit] = s;
      endcase
      e.sbit = s;
      e.prob = p;
      n_samples++;
      if (p != 16'd0 && p != 16'hFFFF) n_mid_prob++;
    end else if (r.action > ACT_SAMPLE_LAB ||
                 (r.unit >= NumLab && (r.action == ACT_WR_LAB_WEIGHT ||
                  r.action == ACT_WR_LAB_BIAS || r.action == ACT_SET_LAB_BIT ||
                  r.action == ACT_SAMPLE_LAB))) begin
      n_noise++;
    end
  endtask

  // Offers one request, holding it until accepted, then records the answer
  // it should produce. Valid stays high into the next request unless the
  // sender decides to idle first.
  task automatic send_request(input req_t r);
    res_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    action_i       <= r.action;
    hidden_index_i <= r.hid;
    unit_index_i   <= r.unit;
    weight_value_i <= r.wval;
    bit_value_i    <= r.bval;
    random_value_i <= r.rnd;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(r, e);
    expected_q.insert(expected_q.size(), e);
    n_sent++;
  endtask

  // Drops valid and waits until every answer has been handed back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  function automatic req_t mk_req(logic [3:0] a, int h, int u, int w, int b, int rnd);
    req_t r;
    r.action = a;
    r.hid    = 6'(h);
    r.unit   = 6'(u);
    r.wval   = 16'(w);
    r.bval   = 1'(b);
    r.rnd    = 16'(rnd);
    return r;
  endfunction

  // Streams use a small set of units per layer: the lowest few and the top
  // one, so that the stores they reach can be filled in a short run.
  function automatic int pick_index(int i, int top);
    return (i < PickCount - 1) ? i : top;
  endfunction

  // Mostly small weights so that sums land inside [-8, 8) often enough to
  // give probabilities away from the rails; now and then the full range.
  function automatic int rand_weight();
    if ($urandom_range(3) == 0) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(1023)) - 512;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int   roll;
    int   lab_u;
    roll  = $urandom_range(99);
    lab_u = ($urandom_range(9) == 0) ? $urandom_range(63, NumLab) :
            pick_index($urandom_range(PickCount - 1), NumLab - 1);
    r = mk_req(ACT_SAMPLE_HID, pick_index($urandom_range(PickCount - 1), NumHid - 1),
               pick_index($urandom_range(PickCount - 1), NumVis - 1), rand_weight(),
               $urandom_range(1), $urandom_range(65535));
    if (roll < 15) begin
      r.action = ACT_WR_VIS_WEIGHT;
    end else if (roll < 21) begin
      r.action = ACT_WR_LAB_WEIGHT;
      r.unit   = 6'(lab_u);
    end else if (roll < 23) begin
      r.action = ACT_WR_VIS_BIAS;
    end else if (roll < 25) begin
      r.action = ACT_WR_HID_BIAS;
    end else if (roll < 27) begin
      r.action = ACT_WR_LAB_BIAS;
      r.unit   = 6'(lab_u);
    end else if (roll < 40) begin
      r.action = ACT_SET_VIS_BIT;
    end else if (roll < 47) begin
      r.action = ACT_SET_LAB_BIT;
      r.unit   = 6'(lab_u);
    end else if (roll < 70) begin
      r.action = ACT_SAMPLE_HID;
    end else if (roll < 84) begin
      r.action = ACT_SAMPLE_VIS;
    end else if (roll < 94) begin
      r.action = ACT_SAMPLE_LAB;
      r.unit   = 6'(lab_u);
    end else begin
      r.action = 4'($urandom_range(15, 10));
    end
    return r;
  endfunction

  // Every store entry among the picked units is written first so that no
  // sample ever adds an entry the sampler holds undefined.
  task automatic test_fill_stores();
    for (int hi = 0; hi < PickCount; hi++) begin
      for (int ui = 0; ui < PickCount; ui++) begin
        send_request(mk_req(ACT_WR_VIS_WEIGHT, pick_index(hi, NumHid - 1),
                            pick_index(ui, NumVis - 1), rand_weight(), 0, 0));
      end
      for (int ui = 0; ui < PickCount; ui++) begin
        send_request(mk_req(ACT_WR_LAB_WEIGHT, pick_index(hi, NumHid - 1),
                            pick_index(ui, NumLab - 1), rand_weight(), 0, 0));
      end
      send_request(mk_req(ACT_WR_HID_BIAS, pick_index(hi, NumHid - 1), 0,
                          rand_weight(), 0, 0));
    end
    for (int ui = 0; ui < PickCount; ui++) begin
      send_request(mk_req(ACT_WR_VIS_BIAS, 0, pick_index(ui, NumVis - 1),
                          rand_weight(), 0, 0));
    end
    for (int ui = 0; ui < PickCount; ui++) begin
      send_request(mk_req(ACT_WR_LAB_BIAS, 0, pick_index(ui, NumLab - 1),
                          rand_weight(), 0, 0));
    end
  endtask

  // Rail values, out-of-range label indexes, unused codes and the top random
  // value, which can never produce a set bit.
  task automatic test_directed();
    send_request(mk_req(ACT_WR_HID_BIAS, 63, 0, 32767, 0, 0));
    send_request(mk_req(ACT_SAMPLE_HID, 63, 0, 0, 0, 65535));
    send_request(mk_req(ACT_SAMPLE_HID, 63, 0, 0, 0, 0));
    send_request(mk_req(ACT_WR_HID_BIAS, 0, 0, -32768, 0, 0));
    send_request(mk_req(ACT_SAMPLE_HID, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_WR_VIS_BIAS, 0, 63, 0, 0, 0));
    send_request(mk_req(ACT_SAMPLE_VIS, 0, 63, 0, 0, 32767));
    send_request(mk_req(ACT_SAMPLE_VIS, 0, 63, 0, 0, 32768));
    send_request(mk_req(ACT_SET_VIS_BIT, 0, 0, 0, 1, 0));
    send_request(mk_req(ACT_SET_VIS_BIT, 0, 63, 0, 1, 0));
    send_request(mk_req(ACT_WR_VIS_WEIGHT, 5, 63, 32767, 0, 0));
    send_request(mk_req(ACT_SET_LAB_BIT, 0, 31, 0, 1, 0));
    send_request(mk_req(ACT_SAMPLE_HID, 5, 0, 0, 0, 65535));
    send_request(mk_req(ACT_SAMPLE_LAB, 0, 31, 0, 0, 12345));
    send_request(mk_req(ACT_SAMPLE_LAB, 0, 32, 0, 0, 0));
    send_request(mk_req(ACT_SET_LAB_BIT, 0, 63, 0, 1, 0));
    send_request(mk_req(ACT_WR_LAB_BIAS, 0, 40, 100, 0, 0));
    send_request(mk_req(ACT_WR_LAB_WEIGHT, 63, 33, -1, 0, 0));
    send_request(mk_req(4'd10, 63, 63, -1, 1, 65535));
    send_request(mk_req(4'd15, 63, 63, -1, 1, 65535));
    send_request(mk_req(ACT_SET_VIS_BIT, 0, 0, 0, 0, 0));
    send_request(mk_req(ACT_SAMPLE_VIS, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) send_request(rand_request());
    wait_drained();
  endtask

  // The receiver stalls for a long stretch while requests keep coming, so the
  // sampler fills up and holds off its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 600;
    for (int i = 0; i < 20; i++) send_request(rand_request());
    wait_drained();
  endtask

  // Result checker and receiver idling.
  always @(posedge clk_i) begin
    res_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result: bit=%0b prob=%0d", sample_bit_o, probability_o);
        end
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (e.sbit !== sample_bit_o || e.prob !== probability_o) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("mismatch on result %0d: expected bit=%0b prob=%0d, got bit=%0b prob=%0d",
                     checked, e.sbit, e.prob, sample_bit_o, probability_o);
          end
        end
      end
    end
    if (recv_hold > 0) begin
      recv_hold   <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_sigmoid_lut();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_stores();
    wait_drained();
    test_directed();
    test_random(370, 6, 69);
    test_random(370, 69, 6);
    test_random(370, 0, 0);
    test_output_stall();

    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d requests: %0d samples (%0d off the rails), %0d no-op requests.",
             n_sent, n_samples, n_mid_prob, n_noise);
    $display("Checked %0d results, %0d mismatches, %0d left over.",
             checked, mismatches, expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
